/* rtl/whpc_pkg.sv */
// ----------------------------------------------------------------------------
// whpc_pkg
// Shared sizes, types and helpers of the window hole pixel counter.
// ----------------------------------------------------------------------------
`default_nettype none

package whpc_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int WIN        = 5;
    localparam int HALF_WIN   = WIN / 2;
    localparam int BG_LIMIT   = (WIN * WIN) / 2;

    localparam int PIX_W  = 2;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int FW_W   = 12;
    localparam int FH_W   = 13;
    localparam int HIST_W = (WIN - 1) * PIX_W;
    localparam int BGC_W  = $clog2(WIN * WIN + 1);
    localparam int CNT_W  = 24;

    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = FW_W'(1632);
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(215);

    localparam logic [PIX_W-1:0] CLS_BACKGROUND = 2'd0;
    localparam logic [PIX_W-1:0] CLS_MODEL      = 2'd1;

    typedef logic [WIN-1:0][PIX_W-1:0] column_t;
    typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic valid;
        logic eval;
        logic last;
    } ctl_t;

    typedef enum logic [2:0] {
        V_NONE,
        V_MODEL,
        V_SUPPORT,
        V_MODEL_HOLE,
        V_SUPPORT_HOLE
    } verdict_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v, input logic en);
        logic [CNT_W-1:0] r;
        r = v;
        if (en && (v != {CNT_W{1'b1}}))
        begin
            r = v + CNT_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/whpc_ram.sv */
// ----------------------------------------------------------------------------
// whpc_ram
// Generic single-clock ram, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module whpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/whpc_window.sv */
// ----------------------------------------------------------------------------
// whpc_window
// Raster position, column history read-modify-write and the 5x5 window.
// ----------------------------------------------------------------------------
`default_nettype none

module whpc_window (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic [whpc_pkg::PIX_W-1:0]  pixel,
    input  wire logic [whpc_pkg::FW_W-1:0]   frame_width,
    input  wire logic [whpc_pkg::FH_W-1:0]   frame_height,
    output logic                             pos_last,
    output logic                             ram_re,
    output logic [whpc_pkg::COL_W-1:0]       ram_raddr,
    input  wire logic [whpc_pkg::HIST_W-1:0] ram_rdata,
    output logic                             ram_we,
    output logic [whpc_pkg::COL_W-1:0]       ram_waddr,
    output logic [whpc_pkg::HIST_W-1:0]      ram_wdata,
    output whpc_pkg::ctl_t                   stage1_ctl,
    output whpc_pkg::ctl_t                   win_ctl,
    output whpc_pkg::window_t                window
);

    logic [whpc_pkg::COL_W-1:0] col_reg;
    logic [whpc_pkg::COL_W-1:0] col_next;
    logic [whpc_pkg::ROW_W-1:0] row_reg;
    logic [whpc_pkg::ROW_W-1:0] row_next;

    whpc_pkg::ctl_t             s1_ctl_reg;
    whpc_pkg::ctl_t             s1_ctl_next;
    logic [whpc_pkg::PIX_W-1:0] s1_pixel_reg;
    logic [whpc_pkg::COL_W-1:0] s1_col_reg;

    whpc_pkg::ctl_t    win_ctl_reg;
    whpc_pkg::window_t win_reg;
    whpc_pkg::window_t win_next;
    whpc_pkg::column_t col_new;

    logic [whpc_pkg::FW_W-1:0] w_eff;
    logic [whpc_pkg::FH_W-1:0] h_eff;
    logic                      row_end;
    logic                      frame_end;

    // clamp sizes and step the raster position
    always_comb
    begin
        if (frame_width < whpc_pkg::FW_W'(whpc_pkg::WIN))
        begin
            w_eff = whpc_pkg::FW_W'(whpc_pkg::WIN);
        end
        else if (frame_width > whpc_pkg::FW_W'(whpc_pkg::MAX_WIDTH))
        begin
            w_eff = whpc_pkg::FW_W'(whpc_pkg::MAX_WIDTH);
        end
        else
        begin
            w_eff = frame_width;
        end

        if (frame_height < whpc_pkg::FH_W'(whpc_pkg::WIN))
        begin
            h_eff = whpc_pkg::FH_W'(whpc_pkg::WIN);
        end
        else if (frame_height > whpc_pkg::FH_W'(whpc_pkg::MAX_HEIGHT))
        begin
            h_eff = whpc_pkg::FH_W'(whpc_pkg::MAX_HEIGHT);
        end
        else
        begin
            h_eff = frame_height;
        end

        row_end   = (({1'b0, col_reg} + (whpc_pkg::COL_W + 1)'(1)) >= w_eff);
        frame_end = row_end
                    && (({1'b0, row_reg} + (whpc_pkg::ROW_W + 1)'(1)) >= h_eff);
        pos_last  = frame_end;

        if (row_end)
        begin
            col_next = '0;
            row_next = frame_end ? '0 : row_reg + whpc_pkg::ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + whpc_pkg::COL_W'(1);
            row_next = row_reg;
        end

        s1_ctl_next.valid = accept;
        s1_ctl_next.eval  = (row_reg >= whpc_pkg::ROW_W'(whpc_pkg::WIN - 1))
                            && (col_reg >= whpc_pkg::COL_W'(whpc_pkg::WIN - 1));
        s1_ctl_next.last  = frame_end;
    end

    // new column, oldest row first
    always_comb
    begin
        for (int k = 0; k < whpc_pkg::WIN - 1; k++)
        begin
            col_new[k] = ram_rdata[(whpc_pkg::WIN - 2 - k) * whpc_pkg::PIX_W +: whpc_pkg::PIX_W];
        end
        col_new[whpc_pkg::WIN-1] = s1_pixel_reg;

        for (int dx = 0; dx < whpc_pkg::WIN - 1; dx++)
        begin
            win_next[dx] = win_reg[dx+1];
        end
        win_next[whpc_pkg::WIN-1] = col_new;
    end

    assign ram_re    = accept;
    assign ram_raddr = col_reg;
    assign ram_we    = s1_ctl_reg.valid;
    assign ram_waddr = s1_col_reg;
    assign ram_wdata = {ram_rdata[whpc_pkg::HIST_W-whpc_pkg::PIX_W-1:0], s1_pixel_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            s1_ctl_reg  <= '0;
            win_ctl_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            s1_ctl_reg  <= accept ? s1_ctl_next : '0;
            win_ctl_reg <= s1_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_reg;
        end
        if (s1_ctl_reg.valid)
        begin
            win_reg <= win_next;
        end
    end

    assign stage1_ctl = s1_ctl_reg;
    assign win_ctl    = win_ctl_reg;
    assign window     = win_reg;

endmodule

`default_nettype wire

/* rtl/whpc_classify.sv */
// ----------------------------------------------------------------------------
// whpc_classify
// Tallies one window and registers the verdict for its centre pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module whpc_classify (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire whpc_pkg::ctl_t     in_ctl,
    input  wire whpc_pkg::window_t  window,
    output whpc_pkg::ctl_t          out_ctl,
    output whpc_pkg::verdict_t      verdict
);

    whpc_pkg::ctl_t     ctl_reg;
    whpc_pkg::verdict_t verdict_reg;
    whpc_pkg::verdict_t verdict_next;

    logic [whpc_pkg::BGC_W-1:0] bg_cnt;
    logic                       has_model;
    logic                       has_support;
    logic [whpc_pkg::PIX_W-1:0] centre;

    always_comb
    begin
        bg_cnt      = '0;
        has_model   = 1'b0;
        has_support = 1'b0;
        for (int dx = 0; dx < whpc_pkg::WIN; dx++)
        begin
            for (int dy = 0; dy < whpc_pkg::WIN; dy++)
            begin
                bg_cnt = bg_cnt
                         + whpc_pkg::BGC_W'(window[dx][dy] == whpc_pkg::CLS_BACKGROUND);
                has_model   = has_model | (window[dx][dy] == whpc_pkg::CLS_MODEL);
                has_support = has_support | window[dx][dy][1];
            end
        end
        centre = window[whpc_pkg::HALF_WIN][whpc_pkg::HALF_WIN];

        verdict_next = whpc_pkg::V_NONE;
        if (in_ctl.eval)
        begin
            if (centre == whpc_pkg::CLS_MODEL)
            begin
                verdict_next = whpc_pkg::V_MODEL;
            end
            else if (centre[1])
            begin
                verdict_next = whpc_pkg::V_SUPPORT;
            end
            else if (bg_cnt < whpc_pkg::BGC_W'(whpc_pkg::BG_LIMIT))
            begin
                if (has_model && !has_support)
                begin
                    verdict_next = whpc_pkg::V_MODEL_HOLE;
                end
                else if (has_support && !has_model)
                begin
                    verdict_next = whpc_pkg::V_SUPPORT_HOLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ctl.valid)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign out_ctl = ctl_reg;
    assign verdict = verdict_reg;

endmodule

`default_nettype wire

/* rtl/whpc_tally.sv */
// ----------------------------------------------------------------------------
// whpc_tally
// Saturating frame totals and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module whpc_tally (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire whpc_pkg::ctl_t              in_ctl,
    input  wire whpc_pkg::verdict_t          verdict,
    input  wire logic                        out_ready,
    output logic                             out_valid,
    output logic [whpc_pkg::CNT_W-1:0]       model_count,
    output logic [whpc_pkg::CNT_W-1:0]       support_count,
    output logic [whpc_pkg::CNT_W-1:0]       model_hole_count,
    output logic [whpc_pkg::CNT_W-1:0]       support_hole_count
);

    logic [whpc_pkg::CNT_W-1:0] model_reg;
    logic [whpc_pkg::CNT_W-1:0] support_reg;
    logic [whpc_pkg::CNT_W-1:0] model_hole_reg;
    logic [whpc_pkg::CNT_W-1:0] support_hole_reg;
    logic [whpc_pkg::CNT_W-1:0] model_next;
    logic [whpc_pkg::CNT_W-1:0] support_next;
    logic [whpc_pkg::CNT_W-1:0] model_hole_next;
    logic [whpc_pkg::CNT_W-1:0] support_hole_next;

    logic                       out_valid_reg;
    logic [whpc_pkg::CNT_W-1:0] out_model_reg;
    logic [whpc_pkg::CNT_W-1:0] out_support_reg;
    logic [whpc_pkg::CNT_W-1:0] out_model_hole_reg;
    logic [whpc_pkg::CNT_W-1:0] out_support_hole_reg;

    logic emit;

    always_comb
    begin
        model_next        = whpc_pkg::sat_inc(model_reg,
                                in_ctl.valid && (verdict == whpc_pkg::V_MODEL));
        support_next      = whpc_pkg::sat_inc(support_reg,
                                in_ctl.valid && (verdict == whpc_pkg::V_SUPPORT));
        model_hole_next   = whpc_pkg::sat_inc(model_hole_reg,
                                in_ctl.valid && (verdict == whpc_pkg::V_MODEL_HOLE));
        support_hole_next = whpc_pkg::sat_inc(support_hole_reg,
                                in_ctl.valid && (verdict == whpc_pkg::V_SUPPORT_HOLE));
        emit = in_ctl.valid && in_ctl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg        <= '0;
            support_reg      <= '0;
            model_hole_reg   <= '0;
            support_hole_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                model_reg        <= '0;
                support_reg      <= '0;
                model_hole_reg   <= '0;
                support_hole_reg <= '0;
            end
            else
            begin
                model_reg        <= model_next;
                support_reg      <= support_next;
                model_hole_reg   <= model_hole_next;
                support_hole_reg <= support_hole_next;
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_model_reg        <= model_next;
            out_support_reg      <= support_next;
            out_model_hole_reg   <= model_hole_next;
            out_support_hole_reg <= support_hole_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign model_count        = out_model_reg;
    assign support_count      = out_support_reg;
    assign model_hole_count   = out_model_hole_reg;
    assign support_hole_count = out_support_hole_reg;

endmodule

`default_nettype wire

/* rtl/window_hole_pixel_counter_top.sv */
// ----------------------------------------------------------------------------
// window_hole_pixel_counter_top
// Counts model, support and hole pixels of a class-pixel frame.
// ----------------------------------------------------------------------------
// Takes one 2-bit class pixel per clock in raster order and, on the frame's
// last pixel, delivers one word with the four frame totals once that pixel
// has passed the stage-1, window, classify and tally output registers.
// The four rows above the current pixel live in a 2048 x 8 column-history ram
// that is read as a pixel is accepted and written back the next cycle;
// the input stalls only when a frame's last pixel arrives while the
// previous frame's totals have not yet been taken.
`default_nettype none

module window_hole_pixel_counter_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_wr_en,
    input  wire logic [whpc_pkg::REG_IDX_W-1:0]    cfg_index,
    input  wire logic [whpc_pkg::FH_W-1:0]         cfg_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,   // pixel_class
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // model_count, support_count, model_hole_count, support_hole_count
    output logic [4*whpc_pkg::CNT_W-1:0]           m_tdata
);

    logic [whpc_pkg::FW_W-1:0] frame_width_reg;
    logic [whpc_pkg::FH_W-1:0] frame_height_reg;

    logic accept;
    logic pos_last;

    logic                        ram_re;
    logic [whpc_pkg::COL_W-1:0]  ram_raddr;
    logic [whpc_pkg::HIST_W-1:0] ram_rdata;
    logic                        ram_we;
    logic [whpc_pkg::COL_W-1:0]  ram_waddr;
    logic [whpc_pkg::HIST_W-1:0] ram_wdata;

    whpc_pkg::ctl_t     stage1_ctl;
    whpc_pkg::ctl_t     win_ctl;
    whpc_pkg::window_t  window;
    whpc_pkg::ctl_t     cls_ctl;
    whpc_pkg::verdict_t verdict;

    logic                       out_valid;
    logic [whpc_pkg::CNT_W-1:0] model_count;
    logic [whpc_pkg::CNT_W-1:0] support_count;
    logic [whpc_pkg::CNT_W-1:0] model_hole_count;
    logic [whpc_pkg::CNT_W-1:0] support_hole_count;
    logic                       last_in_flight;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= whpc_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= whpc_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                whpc_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[whpc_pkg::FW_W-1:0];
                whpc_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                default:                    frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    assign last_in_flight = (stage1_ctl.valid && stage1_ctl.last)
                            || (win_ctl.valid && win_ctl.last)
                            || (cls_ctl.valid && cls_ctl.last);
    assign s_tready = !(pos_last && (out_valid || last_in_flight));
    assign accept   = s_tvalid && s_tready;

    whpc_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pixel        (s_tdata[whpc_pkg::PIX_W-1:0]),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pos_last     (pos_last),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .stage1_ctl   (stage1_ctl),
        .win_ctl      (win_ctl),
        .window       (window)
    );

    whpc_ram #(
        .WIDTH (whpc_pkg::HIST_W),
        .DEPTH (whpc_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    whpc_classify u_classify (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ctl  (win_ctl),
        .window  (window),
        .out_ctl (cls_ctl),
        .verdict (verdict)
    );

    whpc_tally u_tally (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_ctl             (cls_ctl),
        .verdict            (verdict),
        .out_ready          (m_tready),
        .out_valid          (out_valid),
        .model_count        (model_count),
        .support_count      (support_count),
        .model_hole_count   (model_hole_count),
        .support_hole_count (support_hole_count)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {support_hole_count, model_hole_count, support_count, model_count};

    // a frame result never lands on a result still waiting
    a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (cls_ctl.valid && cls_ctl.last) |-> !out_valid)
        else $error("frame result overwrote a pending result");

    // at most one frame end in the pipeline
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({stage1_ctl.valid && stage1_ctl.last,
                    win_ctl.valid && win_ctl.last,
                    cls_ctl.valid && cls_ctl.last}) <= 1)
        else $error("more than one frame end in flight");

    // write-back never collides with the look-ahead read
    a_ram_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("column ram read and write hit the same entry");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Frame-level check of the window hole pixel counter.
// ----------------------------------------------------------------------------
// Streams frames of class pixels through the counter and compares every totals
// word with typed totals or a cycle-free model of the 5x5 window classification
// kept in this bench. A short table of hand-built frames comes first. It covers
// flat classes, a centred hole, a mixed window, the background-count bound,
// clamped frame sizes and random and noise frames. Random frames of small sizes
// follow, mostly clustered content with some noise. Both stream sides idle at
// random, and the frame size is changed only once all totals have drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import whpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200_000;
    localparam int unsigned DRAIN_LIMIT   = 4000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned RAND_PIXELS   = 1050;
    localparam int unsigned RAND_FRAMES   = 12;

    typedef enum logic [1:0] {
        PIX_BG     = 2'd0,
        PIX_MODEL  = 2'd1,
        PIX_BROWN  = 2'd2,
        PIX_ORANGE = 2'd3
    } pixel_cls_e;

    typedef enum logic [2:0] {
        PAT_FLAT,
        PAT_HOLE,
        PAT_MIXED,
        PAT_SPARSE,
        PAT_RANDOM,
        PAT_NOISE
    } pattern_e;

    typedef struct packed {
        logic [CNT_W-1:0] model;
        logic [CNT_W-1:0] support;
        logic [CNT_W-1:0] model_hole;
        logic [CNT_W-1:0] support_hole;
    } frame_totals_t;

    typedef struct packed {
        logic          typed;
        frame_totals_t totals;
    } frame_note_t;

    typedef struct packed {
        logic [FH_W-1:0] width_reg;
        logic [FH_W-1:0] height_reg;
        pattern_e        kind;
        pixel_cls_e      fill;
        logic [6:0]      arg;
        frame_note_t     note;
    } frame_case_t;

    // width, height, pattern, fill class, arg, {typed, {model, support, holes}}
    localparam frame_case_t CASES [18] = '{
        '{13'd5,    13'd5,    PAT_FLAT,   PIX_BG,     7'd0,  '{1'b1, '{24'd0, 24'd0, 24'd0, 24'd0}}},
        '{13'd5,    13'd5,    PAT_FLAT,   PIX_MODEL,  7'd0,  '{1'b1, '{24'd1, 24'd0, 24'd0, 24'd0}}},
        '{13'd5,    13'd5,    PAT_FLAT,   PIX_BROWN,  7'd0,  '{1'b1, '{24'd0, 24'd1, 24'd0, 24'd0}}},
        '{13'd5,    13'd5,    PAT_FLAT,   PIX_ORANGE, 7'd0,  '{1'b1, '{24'd0, 24'd1, 24'd0, 24'd0}}},
        '{13'd5,    13'd5,    PAT_HOLE,   PIX_MODEL,  7'd0,  '{1'b1, '{24'd0, 24'd0, 24'd1, 24'd0}}},
        '{13'd5,    13'd5,    PAT_HOLE,   PIX_BROWN,  7'd0,  '{1'b1, '{24'd0, 24'd0, 24'd0, 24'd1}}},
        '{13'd5,    13'd5,    PAT_HOLE,   PIX_ORANGE, 7'd0,  '{1'b1, '{24'd0, 24'd0, 24'd0, 24'd1}}},
        '{13'd5,    13'd5,    PAT_MIXED,  PIX_MODEL,  7'd0,  '{1'b1, '{24'd0, 24'd0, 24'd0, 24'd0}}},
        '{13'd5,    13'd5,    PAT_SPARSE, PIX_MODEL,  7'd10, '{1'b1, '{24'd0, 24'd0, 24'd1, 24'd0}}},
        '{13'd5,    13'd5,    PAT_SPARSE, PIX_MODEL,  7'd11, '{1'b1, '{24'd0, 24'd0, 24'd0, 24'd0}}},
        '{13'd5,    13'd5,    PAT_SPARSE, PIX_ORANGE, 7'd10, '{1'b1, '{24'd0, 24'd0, 24'd0, 24'd1}}},
        '{13'd0,    13'd0,    PAT_FLAT,   PIX_MODEL,  7'd0,  '{1'b1, '{24'd1, 24'd0, 24'd0, 24'd0}}},
        '{13'd4,    13'd6,    PAT_FLAT,   PIX_MODEL,  7'd0,  '{1'b1, '{24'd2, 24'd0, 24'd0, 24'd0}}},
        '{13'd3,    13'd7,    PAT_FLAT,   PIX_BROWN,  7'd0,  '{1'b1, '{24'd0, 24'd3, 24'd0, 24'd0}}},
        '{13'd7,    13'd6,    PAT_RANDOM, PIX_MODEL,  7'd20, '{1'b0, '0}},
        '{13'd20,   13'd6,    PAT_RANDOM, PIX_BROWN,  7'd25, '{1'b0, '0}},
        '{13'd5,    13'd40,   PAT_RANDOM, PIX_MODEL,  7'd30, '{1'b0, '0}},
        '{13'd9,    13'd7,    PAT_NOISE,  PIX_BG,     7'd0,  '{1'b0, '0}}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [FH_W-1:0]      cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [4*CNT_W-1:0]   m_tdata;

    // frame model state
    logic [PIX_W-1:0] line_mem [WIN][MAX_WIDTH];
    int unsigned      col_pos = 0;
    int unsigned      row_pos = 0;
    frame_totals_t    run_totals = '0;
    logic [FW_W-1:0]  cfg_width = FRAME_WIDTH_RESET;
    logic [FH_W-1:0]  cfg_height = FRAME_HEIGHT_RESET;

    frame_totals_t totals_due [$];
    frame_note_t   frame_notes [$];

    int          errors = 0;
    int unsigned tx_idle_pct = 17;
    int unsigned rx_idle_pct = 59;
    int unsigned rx_hold = 0;
    int unsigned pixels_sent = 0;
    int unsigned cycle_count = 0;

    window_hole_pixel_counter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // receiver backpressure, with an occasional long hold
    always @(posedge clk)
    begin
        if (rx_hold != 0)
        begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < rx_idle_pct)
        begin
            m_tready <= 1'b0;
            if ($urandom_range(0, 39) == 0)
            begin
                rx_hold <= $urandom_range(20, 60);
            end
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
        if (v < WIN)
        begin
            return WIN;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic count_pixel(input logic [PIX_W-1:0] cls, output logic done,
                               output frame_totals_t res);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        int unsigned      tally [4];
        int unsigned      sup;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] centre;
        w = eff_size(cfg_width, MAX_WIDTH);
        h = eff_size(cfg_height, MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        done = 1'b0;
        res = '0;
        centre = PIX_BG;
        line_mem[r % WIN][c] = cls;
        if (r >= WIN - 1 && c >= WIN - 1)
        begin
            tally = '{0, 0, 0, 0};
            for (int dy = 0; dy < WIN; dy++)
            begin
                for (int dx = 0; dx < WIN; dx++)
                begin
                    pix = line_mem[(r + 1 + dy) % WIN][c + 1 + dx - WIN];
                    tally[pix]++;
                    if (dy == HALF_WIN && dx == HALF_WIN)
                    begin
                        centre = pix;
                    end
                end
            end
            sup = tally[PIX_BROWN] + tally[PIX_ORANGE];
            if (centre == PIX_MODEL)
            begin
                run_totals.model = bump(run_totals.model);
            end
            else if (centre != PIX_BG)
            begin
                run_totals.support = bump(run_totals.support);
            end
            else if (tally[PIX_BG] < BG_LIMIT)
            begin
                if (tally[PIX_MODEL] != 0 && sup == 0)
                begin
                    run_totals.model_hole = bump(run_totals.model_hole);
                end
                else if (sup != 0 && tally[PIX_MODEL] == 0)
                begin
                    run_totals.support_hole = bump(run_totals.support_hole);
                end
            end
        end
        if (c + 1 >= w)
        begin
            col_pos = 0;
            if (r + 1 >= h)
            begin
                res = run_totals;
                run_totals = '0;
                row_pos = 0;
                done = 1'b1;
            end
            else
            begin
                row_pos = r + 1;
            end
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        frame_totals_t got;
        frame_totals_t want;
        frame_totals_t pred;
        frame_note_t   note;
        logic          done;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.model        = m_tdata[CNT_W-1:0];
                got.support      = m_tdata[2*CNT_W-1:CNT_W];
                got.model_hole   = m_tdata[3*CNT_W-1:2*CNT_W];
                got.support_hole = m_tdata[4*CNT_W-1:3*CNT_W];
                if (totals_due.size() == 0)
                begin
                    report_mismatch("unexpected word, model_count", got.model, 0);
                end
                else
                begin
                    want = totals_due.pop_front();
                    if (got.model != want.model)
                    begin
                        report_mismatch("model_count", got.model, want.model);
                    end
                    if (got.support != want.support)
                    begin
                        report_mismatch("support_count", got.support, want.support);
                    end
                    if (got.model_hole != want.model_hole)
                    begin
                        report_mismatch("model_hole_count", got.model_hole,
                                        want.model_hole);
                    end
                    if (got.support_hole != want.support_hole)
                    begin
                        report_mismatch("support_hole_count", got.support_hole,
                                        want.support_hole);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                count_pixel(s_tdata[PIX_W-1:0], done, pred);
                if (done)
                begin
                    note = frame_notes.pop_front();
                    totals_due.push_back(note.typed ? note.totals : pred);
                end
            end
        end
    end

    task automatic send_pixel(input pixel_cls_e cls);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, cls};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        repeat (DRAIN_LIMIT)
        begin
            if (totals_due.size() == 0)
            begin
                break;
            end
            @(posedge clk);
        end
        if (totals_due.size() != 0)
        begin
            report_mismatch("missing words", 0, totals_due.size());
            totals_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_size(input int unsigned w, input int unsigned h);
        wait_drained();
        cfg_wr_en  <= 1'b1;
        cfg_index  <= REG_FRAME_WIDTH;
        cfg_data   <= {1'b0, w[FW_W-1:0]};
        cfg_width  = w[FW_W-1:0];
        @(posedge clk);
        cfg_index  <= REG_FRAME_HEIGHT;
        cfg_data   <= h[FH_W-1:0];
        cfg_height = h[FH_W-1:0];
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
    endtask

    task automatic run_frame(input pattern_e kind, input pixel_cls_e fill, input int unsigned arg,
                             input frame_note_t note);
        int unsigned w;
        int unsigned h;
        int unsigned ctr;
        int unsigned roll;
        pixel_cls_e  cls;
        w = eff_size(cfg_width, MAX_WIDTH);
        h = eff_size(cfg_height, MAX_HEIGHT);
        ctr = 2 * w + 2;
        frame_notes.push_back(note);
        for (int unsigned k = 0; k < w * h; k++)
        begin
            cls = fill;
            case (kind)
                PAT_HOLE:
                begin
                    if (k == ctr)
                    begin
                        cls = PIX_BG;
                    end
                end
                PAT_MIXED:
                begin
                    if (k == ctr)
                    begin
                        cls = PIX_BG;
                    end
                    else if (k == 0)
                    begin
                        cls = PIX_BROWN;
                    end
                end
                PAT_SPARSE:
                begin
                    if (k == ctr || k < arg)
                    begin
                        cls = PIX_BG;
                    end
                end
                PAT_RANDOM:
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < arg)
                    begin
                        cls = PIX_BG;
                    end
                    else if (roll < arg + 4)
                    begin
                        cls = (fill == PIX_MODEL) ? pixel_cls_e'($urandom_range(2, 3)) : PIX_MODEL;
                    end
                    else if (fill == PIX_BROWN || fill == PIX_ORANGE)
                    begin
                        cls = pixel_cls_e'($urandom_range(2, 3));
                    end
                end
                PAT_NOISE:
                begin
                    cls = pixel_cls_e'($urandom_range(0, 3));
                end
                default:
                begin
                    cls = fill;
                end
            endcase
            send_pixel(cls);
            pixels_sent++;
        end
    endtask

    initial
    begin : stimulus
        frame_case_t row;
        int unsigned base;
        int unsigned frames;
        int unsigned w;
        int unsigned h;
        int unsigned sel;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (CASES[i])
        begin
            row = CASES[i];
            set_size(row.width_reg, row.height_reg);
            run_frame(row.kind, row.fill, row.arg, row.note);
        end

        base = pixels_sent;
        frames = 0;
        while (pixels_sent - base < RAND_PIXELS || frames < RAND_FRAMES)
        begin
            if (pixels_sent - base < RAND_PIXELS / 3)
            begin
                tx_idle_pct = 17;
                rx_idle_pct = 59;
            end
            else if (pixels_sent - base < 2 * RAND_PIXELS / 3)
            begin
                tx_idle_pct = 59;
                rx_idle_pct = 17;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            sel = $urandom_range(0, 19);
            if (sel == 0)
            begin
                w = $urandom_range(0, 4);
                h = $urandom_range(5, 8);
            end
            else if (sel == 1)
            begin
                w = $urandom_range(5, 8);
                h = $urandom_range(0, 4);
            end
            else if (sel == 2)
            begin
                w = $urandom_range(13, 48);
                h = $urandom_range(5, 8);
            end
            else
            begin
                w = $urandom_range(5, 12);
                h = $urandom_range(5, 10);
            end
            set_size(w, h);
            // back-to-back frames at one size
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    run_frame(PAT_NOISE, PIX_BG, 0, '{1'b0, '0});
                end
                else
                begin
                    run_frame(PAT_RANDOM, pixel_cls_e'($urandom_range(0, 3)),
                              $urandom_range(0, 60), '{1'b0, '0});
                end
                frames++;
            end
        end

        wait_drained();
        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
